// ----- sv/olis_pkg.sv -----
// Shared types and constants for the ordered list with insert, remove and search.
`timescale 1ns / 1ps

package olis_pkg;

   // Default number of list entries.
   localparam int LIST_DEPTH = 128;

   // Width of one stored value.
   localparam int VALUE_W = 32;

   // Request modes.
   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_SEARCH = 2'd3
   } mode_type;

   // Result status codes.
   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FAIL = 1'b1
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_SEARCH,
      ST_RESP
   } state_type;

   // Request word.
   typedef struct packed {
      mode_type                   mode;
      logic [7:0]                 position;
      logic signed [VALUE_W-1:0]  item_value;
   } req_type;

   // Response word.
   typedef struct packed {
      status_type  status;
      logic [6:0]  found_position;
      logic [7:0]  entry_count;
   } rsp_type;

endpackage

// ----- sv/olis_ram.sv -----
// Simple dual-port list memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module olis_ram #(
   parameter int DEPTH = olis_pkg::LIST_DEPTH,
   parameter int AW    = 7
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [olis_pkg::VALUE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [olis_pkg::VALUE_W-1:0] rd_data
);

   logic [olis_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [olis_pkg::VALUE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ordered_list_insert_remove_search.sv -----
// Ordered list of signed 32-bit values with append, insert, remove and search.
// The list lives in one simple dual-port memory that moves or compares one entry per
// cycle, so a word takes time in proportion to the entries it touches: insert and
// remove move the entries from the position to the end, and search reads entries
// until the first match or the end. A new request word is taken once the previous
// one has reached the output register, even while that response word is still
// stalled.
`timescale 1ns / 1ps

module ordered_list_insert_remove_search #(
   parameter int LIST_DEPTH = olis_pkg::LIST_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  olis_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output olis_pkg::rsp_type rsp_data
);

   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);

   olis_pkg::state_type          state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [IW-1:0]                cur_ff, cur_in;
   logic [IW-1:0]                pos_ff, pos_in;
   logic [olis_pkg::VALUE_W-1:0] val_ff, val_in;
   logic                         up_ff, up_in;
   logic                         issue_ff, issue_in;
   logic                         pend_ff, pend_in;
   logic [IW-1:0]                pend_addr_ff, pend_addr_in;
   olis_pkg::status_type         status_ff, status_in;
   logic [IW-1:0]                found_ff, found_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   olis_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                         wr_en;
   logic [IW-1:0]                wr_addr;
   logic [olis_pkg::VALUE_W-1:0] wr_data;
   logic                         rd_en;
   logic [IW-1:0]                rd_addr;
   logic [olis_pkg::VALUE_W-1:0] rd_data;

   logic [31:0]                  cnt32;
   logic [31:0]                  pos32;
   logic [31:0]                  last32;
   logic [31:0]                  found32;
   logic                         last_read;

   olis_ram #(
      .DEPTH (LIST_DEPTH),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Requests are taken only while the controller waits for one.
   assign req_stall = (state_ff != olis_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Widened copies for range checks that hold at any list depth.
   assign cnt32   = 32'(count_ff);
   assign last32  = cnt32 - 32'd1;
   assign found32 = 32'(found_ff);

   // Next state and memory control.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      up_in        = up_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = cur_ff;
      pos32        = 32'(req_data.position);
      last_read    = 1'b0;

      // The output register empties when its word is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         olis_pkg::ST_IDLE: begin
            if (req_valid) begin
               val_in    = req_data.item_value;
               status_in = olis_pkg::STATUS_FAIL;
               found_in  = '0;
               issue_in  = 1'b1;
               pend_in   = 1'b0;
               if (req_data.mode == olis_pkg::MODE_APPEND) begin
                  pos32 = cnt32;
               end
               case (req_data.mode)
                  olis_pkg::MODE_APPEND, olis_pkg::MODE_INSERT: begin
                     if (cnt32 < 32'(LIST_DEPTH) && pos32 <= cnt32) begin
                        status_in = olis_pkg::STATUS_OK;
                        pos_in    = pos32[IW-1:0];
                        if (pos32 == cnt32) begin
                           state_in = olis_pkg::ST_PLACE;
                        end else begin
                           // Move entries up, starting from the last one.
                           state_in = olis_pkg::ST_SHIFT;
                           up_in    = 1'b1;
                           cur_in   = last32[IW-1:0];
                        end
                     end else begin
                        state_in = olis_pkg::ST_RESP;
                     end
                  end
                  olis_pkg::MODE_REMOVE: begin
                     if (pos32 < cnt32) begin
                        status_in = olis_pkg::STATUS_OK;
                        pos_in    = pos32[IW-1:0];
                        if (pos32 == last32) begin
                           count_in = count_ff - CW'(1);
                           state_in = olis_pkg::ST_RESP;
                        end else begin
                           // Move entries down, starting just above the hole.
                           state_in = olis_pkg::ST_SHIFT;
                           up_in    = 1'b0;
                           cur_in   = pos32[IW-1:0] + IW'(1);
                        end
                     end else begin
                        state_in = olis_pkg::ST_RESP;
                     end
                  end
                  default: begin
                     if (cnt32 == 32'd0) begin
                        state_in = olis_pkg::ST_RESP;
                     end else begin
                        state_in = olis_pkg::ST_SEARCH;
                        cur_in   = '0;
                     end
                  end
               endcase
            end
         end

         olis_pkg::ST_SHIFT: begin
            // Write back the entry read in the previous cycle.
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (issue_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = up_ff ? (cur_ff + IW'(1)) : (cur_ff - IW'(1));
               last_read    = up_ff ? (cur_ff == pos_ff) : (32'(cur_ff) == last32);
               if (last_read) begin
                  issue_in = 1'b0;
               end else begin
                  cur_in = up_ff ? (cur_ff - IW'(1)) : (cur_ff + IW'(1));
               end
            end else begin
               pend_in = 1'b0;
               if (up_ff) begin
                  state_in = olis_pkg::ST_PLACE;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = olis_pkg::ST_RESP;
               end
            end
         end

         olis_pkg::ST_PLACE: begin
            // Store the new value in the opened slot.
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = val_ff;
            count_in = count_ff + CW'(1);
            state_in = olis_pkg::ST_RESP;
         end

         olis_pkg::ST_SEARCH: begin
            // Read one entry per cycle and compare its registered read data with the value.
            if (issue_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cur_ff;
               if (32'(cur_ff) == last32) begin
                  issue_in = 1'b0;
               end else begin
                  cur_in = cur_ff + IW'(1);
               end
            end
            if (pend_ff && rd_data == val_ff) begin
               status_in = olis_pkg::STATUS_OK;
               found_in  = pend_addr_ff;
               issue_in  = 1'b0;
               pend_in   = 1'b0;
               state_in  = olis_pkg::ST_RESP;
            end else if (pend_ff && !issue_ff) begin
               pend_in  = 1'b0;
               state_in = olis_pkg::ST_RESP;
            end
         end

         olis_pkg::ST_RESP: begin
            // Load the response word once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = status_ff;
               rsp_data_in.found_position = found32[6:0];
               rsp_data_in.entry_count    = cnt32[7:0];
               state_in                   = olis_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = olis_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olis_pkg::ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and cursor registers.
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      up_ff        <= up_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// ----- dv/olis_list_checker.sv -----
// Checker for the ordered list block: predicts each response word and compares it.
`timescale 1ns / 1ps

module olis_list_checker
   import olis_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_words,
   output int      words_done,
   output int      search_hits,
   output int      full_rejects,
   output int      peak_held
);

   // Shadow copy of the list contents and its length.
   logic signed [VALUE_W-1:0] shadow_list [LIST_DEPTH];
   int                        held = 0;

   // Responses predicted for accepted requests, oldest first.
   rsp_type                   due_rsp_q [$];

   int errs     = 0;
   int n_words  = 0;
   int n_hits   = 0;
   int n_full   = 0;
   int n_peak   = 0;

   assign fail_count   = errs;
   assign words_done   = n_words;
   assign search_hits  = n_hits;
   assign full_rejects = n_full;
   assign peak_held    = n_peak;

   // Applies one request word to the shadow list and returns the response it earns.
   function automatic rsp_type apply_request(input req_type w);
      rsp_type r;
      int      tgt;
      int      i;
      int      hit;
      bit      ok;
      ok  = 1'b0;
      hit = 0;
      case (w.mode)
         MODE_APPEND, MODE_INSERT: begin
            tgt = (w.mode == MODE_APPEND) ? held : int'(w.position);
            if (held < LIST_DEPTH && tgt <= held) begin
               for (i = held; i > tgt; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[tgt] = w.item_value;
               held++;
               ok = 1'b1;
            end else if (held == LIST_DEPTH) begin
               n_full++;
            end
         end
         MODE_REMOVE: begin
            tgt = int'(w.position);
            if (tgt < held) begin
               for (i = tgt; i + 1 < held; i++) shadow_list[i] = shadow_list[i+1];
               held--;
               ok = 1'b1;
            end
         end
         default: begin
            // Search stops at the lowest matching position.
            i = 0;
            while (i < held && !ok) begin
               if (shadow_list[i] == w.item_value) begin
                  ok  = 1'b1;
                  hit = i;
               end else begin
                  i++;
               end
            end
            if (ok) n_hits++;
         end
      endcase
      if (held > n_peak) n_peak = held;
      r.status         = ok ? STATUS_OK : STATUS_FAIL;
      r.found_position = 7'(hit);
      r.entry_count    = 8'(held);
      return r;
   endfunction

   // Reports one field that differs from its prediction.
   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errs++;
      end
   endfunction

   // Responses are matched before requests are predicted, so a word accepted at
   // this edge can never be taken for the response arriving at the same edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held = 0;
         due_rsp_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rsp_q.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %h",
                        $time, rsp_data);
               errs++;
            end else begin
               want = due_rsp_q.pop_front();
               check_field("status", int'(want.status), int'(rsp_data.status));
               check_field("found_position", int'(want.found_position),
                           int'(rsp_data.found_position));
               check_field("entry_count", int'(want.entry_count),
                           int'(rsp_data.entry_count));
            end
         end
         if (req_valid && !req_stall) begin
            due_rsp_q.push_back(apply_request(req_data));
            n_words++;
         end
      end
      pending_words <= due_rsp_q.size();
   end

endmodule

// ----- dv/tb_ordered_list_insert_remove_search.sv -----
// Testbench top for the ordered list block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_ordered_list_insert_remove_search;
   import olis_pkg::*;

   localparam int RANDOM_WORDS  = 1450;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int CALM_FIRST    = 700;
   localparam int CALM_LAST     = 900;

   typedef enum logic [1:0] {
      PH_GROW,
      PH_SHRINK,
      PH_MIX
   } stim_phase_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_words;
   int words_done;
   int search_hits;
   int full_rejects;
   int peak_held;

   // Stimulus-side view of the list length, used to aim positions and to steer the phases.
   int unsigned fill        = 0;
   int          sent_random = 0;
   bit          steady      = 1'b0;
   int          cycle_count = 0;

   ordered_list_insert_remove_search DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   olis_list_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_done    (words_done),
      .search_hits   (search_hits),
      .full_rejects  (full_rejects),
      .peak_held     (peak_held)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The response side stalls at random except during the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 37);
   end

   // Hard limit on the run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_ordered_list_insert_remove_search: errors");
         $finish;
      end
   end

   function automatic req_type word(input mode_type m, input logic [7:0] pos,
                                    input logic signed [VALUE_W-1:0] val);
      req_type w;
      w.mode       = m;
      w.position   = pos;
      w.item_value = val;
      return w;
   endfunction

   // Values mostly come from a small pool so that searches find duplicates.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2, 3, 4,
         5, 6:    return $urandom_range(15) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Builds one random word, weighted by the phase of the run.
   function automatic req_type make_word(input stim_phase_type ph);
      req_type     w;
      int unsigned roll;
      w.mode       = MODE_SEARCH;
      w.position   = 8'($urandom_range(255));
      w.item_value = pick_value();
      roll         = $urandom_range(99);
      case (ph)
         PH_GROW: begin
            if (roll < 45) begin
               w.mode = MODE_APPEND;
            end else if (roll < 75) begin
               w.mode     = MODE_INSERT;
               w.position = 8'($urandom_range(fill));
            end else if (roll < 80 && fill > 0) begin
               w.mode     = MODE_REMOVE;
               w.position = 8'($urandom_range(fill - 1));
            end else if (roll >= 95) begin
               w.mode = mode_type'($urandom_range(3));
            end
         end
         PH_SHRINK: begin
            if (roll < 55 && fill > 0) begin
               w.mode     = MODE_REMOVE;
               w.position = 8'($urandom_range(fill - 1));
            end else if (roll < 65) begin
               w.mode     = MODE_REMOVE;
               w.position = 8'($urandom_range(255, fill));
            end else if (roll < 75) begin
               w.mode     = MODE_INSERT;
               w.position = 8'($urandom_range(fill));
            end else if (roll >= 90) begin
               w.mode = mode_type'($urandom_range(3));
            end
         end
         default: begin
            if (roll < 20) begin
               w.mode = MODE_APPEND;
            end else if (roll < 45) begin
               w.mode     = MODE_INSERT;
               w.position = 8'($urandom_range(fill));
            end else if (roll < 70 && fill > 0) begin
               w.mode     = MODE_REMOVE;
               w.position = 8'($urandom_range(fill - 1));
            end else if (roll >= 90) begin
               w.mode = mode_type'($urandom_range(3));
            end
         end
      endcase
      return w;
   endfunction

   // Offers one word, after a random gap outside the calm stretch, and holds it until it is taken.
   task automatic send_word(input req_type w);
      int unsigned gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < 37) gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      case (w.mode)
         MODE_APPEND: if (fill < LIST_DEPTH) fill++;
         MODE_INSERT: if (fill < LIST_DEPTH && w.position <= fill) fill++;
         MODE_REMOVE: if (w.position < fill) fill--;
         default: ;
      endcase
   endtask

   task automatic send_random(input stim_phase_type ph);
      steady = (sent_random >= CALM_FIRST && sent_random < CALM_LAST);
      send_word(make_word(ph));
      sent_random++;
   endtask

   // Holds the sender back until every response has come out.
   task automatic wait_all_out();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: empty list, bad positions, extreme values, duplicates.
      send_word(word(MODE_SEARCH, 8'd0, 32'sd0));
      send_word(word(MODE_REMOVE, 8'd0, 32'sd7));
      send_word(word(MODE_INSERT, 8'd1, 32'sd9));
      send_word(word(MODE_INSERT, 8'd0, 32'sh8000_0000));
      send_word(word(MODE_APPEND, 8'hff, 32'sh7fff_ffff));
      send_word(word(MODE_APPEND, 8'd0, -32'sd1));
      send_word(word(MODE_INSERT, 8'd3, 32'sd0));
      send_word(word(MODE_INSERT, 8'd1, 32'sd5));
      send_word(word(MODE_SEARCH, 8'haa, 32'sh7fff_ffff));
      send_word(word(MODE_SEARCH, 8'd0, -32'sd1));
      send_word(word(MODE_SEARCH, 8'd0, 32'sh8000_0000));
      send_word(word(MODE_SEARCH, 8'd0, 32'sd0));
      send_word(word(MODE_SEARCH, 8'd0, 32'sd12345));
      send_word(word(MODE_APPEND, 8'd0, 32'sd5));
      send_word(word(MODE_SEARCH, 8'd0, 32'sd5));
      send_word(word(MODE_REMOVE, 8'hff, 32'sd0));
      send_word(word(MODE_INSERT, 8'd200, 32'sd1));
      send_word(word(MODE_REMOVE, 8'd6, 32'sd0));
      send_word(word(MODE_REMOVE, 8'd5, 32'sd0));
      send_word(word(MODE_REMOVE, 8'd0, 32'sd0));
      send_word(word(MODE_REMOVE, 8'd1, 32'sd0));
      send_word(word(MODE_SEARCH, 8'd0, 32'sd5));
      wait_all_out();

      // Random rounds: fill to the limit, mix, drain to empty, mix.
      while (sent_random < RANDOM_WORDS) begin
         while (fill < LIST_DEPTH && sent_random < RANDOM_WORDS) send_random(PH_GROW);
         repeat (6) send_random(PH_GROW);
         wait_all_out();
         repeat (60) send_random(PH_MIX);
         while (fill > 0 && sent_random < RANDOM_WORDS) send_random(PH_SHRINK);
         repeat (6) send_random(PH_SHRINK);
         repeat (60) send_random(PH_MIX);
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_words != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d words, %0d searches found a value, peak length %0d.",
               words_done, search_hits, peak_held);
      $display("%0d appends or inserts were turned away by a full list.", full_rejects);
      if (fail_count == 0) begin
         $display("tb_ordered_list_insert_remove_search: clean");
      end else begin
         $display("tb_ordered_list_insert_remove_search: errors");
      end
      $finish;
   end

endmodule
